// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker (bcc_checker.sv).
// Each assumes clock aclk and active-low synchronous reset aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/bcc_pkg.sv =====
// Package for the button click classifier: widths, register indices,
// reset values and the structs passed between the top level and the lanes.
// No dependencies.
package bcc_pkg;

    localparam int BTN_W           = 16;  // buttons carried in one sample
    localparam int NUM_BUTTONS_DEF = 16;

    localparam int DEB_W   = 8;
    localparam int DCLK_W  = 10;
    localparam int LONG_W  = 12;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam int OUT_W = 4 * BTN_W;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_CLICK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 2'd2;

    localparam logic [DEB_W-1:0]  DEB_RST  = 8'd15;
    localparam logic [DCLK_W-1:0] DCLK_RST = 10'd200;
    localparam logic [LONG_W-1:0] LONG_RST = 12'd500;

    typedef struct packed {
        logic [DEB_W-1:0]  debounce_ticks;
        logic [DCLK_W-1:0] double_click_ticks;
        logic [LONG_W-1:0] long_press_ticks;
    } cfg_t;

    typedef struct packed {
        logic single_click;
        logic double_click;
        logic long_press;
        logic pressed;
    } lane_evt_t;

endpackage

// ===== rtl/bcc_lane.sv =====
// One button's debounce and click classification state.
// Depends on bcc_pkg.
module bcc_lane (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step_en,
    input  logic               btn_down,
    input  bcc_pkg::cfg_t      cfg,
    output bcc_pkg::lane_evt_t evt
);
    import bcc_pkg::*;

    logic              last_sample_reg, last_sample_next;
    logic              debounced_reg, debounced_next;
    logic              long_done_reg, long_done_next;
    logic              pending_reg, pending_next;
    logic [DEB_W-1:0]  settle_reg, settle_next;
    logic [LONG_W-1:0] hold_reg, hold_next;
    logic [DCLK_W-1:0] age_reg, age_next;

    // one bit wider than the counters: compares see the unsaturated value
    logic [DEB_W:0]    settle_v;
    logic [LONG_W:0]   hold_v;
    logic [DCLK_W:0]   age_v;
    logic              single_c, double_c, long_c;

    always_comb begin
        last_sample_next = btn_down;
        debounced_next   = debounced_reg;
        long_done_next   = long_done_reg;
        pending_next     = pending_reg;
        single_c         = 1'b0;
        double_c         = 1'b0;
        long_c           = 1'b0;

        settle_v = (btn_down != last_sample_reg) ? '0 : {1'b0, settle_reg} + 1'b1;
        hold_v   = {1'b0, hold_reg} + 1'b1;
        age_v    = {1'b0, age_reg} + 1'b1;

        // debounced edge
        if (settle_v >= {1'b0, cfg.debounce_ticks} && btn_down != debounced_reg) begin
            debounced_next = btn_down;
            if (btn_down) begin
                hold_v         = '0;
                long_done_next = 1'b0;
            end else if (!long_done_reg) begin
                if (pending_reg && age_v <= {1'b0, cfg.double_click_ticks}) begin
                    double_c     = 1'b1;
                    pending_next = 1'b0;
                end else begin
                    single_c     = pending_reg;  // older window just ran out
                    pending_next = 1'b1;
                    age_v        = '0;
                end
            end else begin
                pending_next = 1'b0;             // release ending a long press
            end
        end

        if (debounced_next && !long_done_next && hold_v >= {1'b0, cfg.long_press_ticks}) begin
            long_done_next = 1'b1;
            long_c         = 1'b1;
            pending_next   = 1'b0;
        end

        if (pending_next && age_v > {1'b0, cfg.double_click_ticks}) begin
            single_c     = 1'b1;
            pending_next = 1'b0;
        end

        settle_next = settle_v[DEB_W]  ? '1 : settle_v[DEB_W-1:0];
        hold_next   = hold_v[LONG_W]   ? '1 : hold_v[LONG_W-1:0];
        age_next    = age_v[DCLK_W]    ? '1 : age_v[DCLK_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_sample_reg <= 1'b0;
            debounced_reg   <= 1'b0;
            long_done_reg   <= 1'b0;
            pending_reg     <= 1'b0;
            settle_reg      <= '0;
            hold_reg        <= '0;
            age_reg         <= '0;
        end else if (step_en) begin
            last_sample_reg <= last_sample_next;
            debounced_reg   <= debounced_next;
            long_done_reg   <= long_done_next;
            pending_reg     <= pending_next;
            settle_reg      <= settle_next;
            hold_reg        <= hold_next;
            age_reg         <= age_next;
        end
    end

    assign evt.single_click = single_c;
    assign evt.double_click = double_c;
    assign evt.long_press   = long_c;
    assign evt.pressed      = debounced_next;

endmodule

// ===== rtl/button_click_classifier.sv =====
// Top level of the button click classifier: stream ports, config registers,
// input and result registers, one bcc_lane per button. Depends on bcc_pkg, bcc_lane.
// Usage
//   s_* : one transaction per poll tick; s_tdata[15:0] = raw_levels, bit i low
//         means button i pressed.
//   m_* : one transaction per input transaction, m_tdata holds from bit 0 up
//         single_mask, double_mask, long_mask, pressed_mask (16 bits each).
//   cfg_* : register writes; index 0 debounce, 1 double-click window,
//         2 long press. Other indices are ignored. cfg_ready is always high.
//         Write only while no transaction is in flight.
// Timing
//   A sample accepted into the input register is turned by the lanes into a
//   result, loaded into the result register once that register is free.
//   Throughput is one transaction per cycle while the result is not stalled.
// Reset: synchronous, active low; clears all button state to released/idle,
//   empties both registers and loads default timings 15 / 200 / 500 ticks.
// Stall
//   When m_tready is low the result holds; an empty input register still takes one
//   more sample, then s_tready drops until the result is taken.
module button_click_classifier #(
    parameter int NUM_BUTTONS = bcc_pkg::NUM_BUTTONS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [bcc_pkg::BTN_W-1:0]        s_tdata,   // [15:0] raw_levels
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [bcc_pkg::OUT_W-1:0]        m_tdata,   // [15:0] single_mask,
                                                        // [31:16] double_mask,
                                                        // [47:32] long_mask,
                                                        // [63:48] pressed_mask
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bcc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bcc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bcc_pkg::*;

    // config registers
    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks     <= DEB_RST;
            cfg_reg.double_click_ticks <= DCLK_RST;
            cfg_reg.long_press_ticks   <= LONG_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_DEBOUNCE:     cfg_reg.debounce_ticks     <= cfg_data[DEB_W-1:0];
                REG_DOUBLE_CLICK: cfg_reg.double_click_ticks <= cfg_data[DCLK_W-1:0];
                REG_LONG_PRESS:   cfg_reg.long_press_ticks   <= cfg_data[LONG_W-1:0];
                default: ;        // unmapped index
            endcase
        end
    end

    // input register
    logic             in_valid_reg;
    logic [BTN_W-1:0] in_levels_reg;
    logic             out_free;
    logic             advance;

    assign out_free = !m_tvalid || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_levels_reg <= s_tdata;
        end
    end

    // per-button lanes
    lane_evt_t        evt [NUM_BUTTONS];
    logic [BTN_W-1:0] single_m, double_m, long_m, pressed_m;

    for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
        logic btn_down;
        if (i < BTN_W) begin : g_wired
            assign btn_down = ~in_levels_reg[i];
        end else begin : g_absent
            assign btn_down = 1'b0;        // no input bit: reads as released
        end

        bcc_lane u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .step_en  (advance),
            .btn_down (btn_down),
            .cfg      (cfg_reg),
            .evt      (evt[i])
        );
    end

    // masks; lanes past bit 15 are dropped, missing lanes read zero
    for (genvar j = 0; j < BTN_W; j++) begin : g_mask
        if (j < NUM_BUTTONS) begin : g_used
            assign single_m[j]  = evt[j].single_click;
            assign double_m[j]  = evt[j].double_click;
            assign long_m[j]    = evt[j].long_press;
            assign pressed_m[j] = evt[j].pressed;
        end else begin : g_unused
            assign single_m[j]  = 1'b0;
            assign double_m[j]  = 1'b0;
            assign long_m[j]    = 1'b0;
            assign pressed_m[j] = 1'b0;
        end
    end

    // result register
    logic             m_valid_reg;
    logic [OUT_W-1:0] m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= {pressed_m, long_m, double_m, single_m};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== rtl/bcc_checker.sv =====
// Port-level checker for button_click_classifier, bound to the top level.
// Depends on bcc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bcc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [bcc_pkg::OUT_W-1:0]     m_tdata
);
    import bcc_pkg::*;

    logic [BTN_W-1:0] single_m, double_m, long_m, pressed_m;
    logic             m_stall;

    assign single_m  = m_tdata[BTN_W-1:0];
    assign double_m  = m_tdata[2*BTN_W-1:BTN_W];
    assign long_m    = m_tdata[3*BTN_W-1:2*BTN_W];
    assign pressed_m = m_tdata[4*BTN_W-1:3*BTN_W];
    assign m_stall   = m_tvalid && !m_tready;

    `ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "result valid after reset")
    `ASSERT_CLK(a_stall_hold, m_stall |=> m_tvalid && $stable(m_tdata), "stalled result changed")
    `ASSERT_CLK(a_one_click, m_tvalid |-> (single_m & double_m) == '0, "single with double")
    `ASSERT_CLK(a_long_held, m_tvalid |-> (long_m & ~pressed_m) == '0, "long while released")

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== verif/click_event_checker.sv =====
// Click event checker: watches the sample, result and register channels of the
// button click classifier, predicts each result mask set and compares it.
// Depends on bcc_pkg.
`timescale 1ns / 1ps

module click_event_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [bcc_pkg::BTN_W-1:0]      s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [bcc_pkg::OUT_W-1:0]      m_tdata,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [bcc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bcc_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             fail_count,
    output int                             results_due
);
    import bcc_pkg::*;

    // m_tdata layout, highest field first
    typedef struct packed {
        logic [BTN_W-1:0] pressed_m;
        logic [BTN_W-1:0] long_m;
        logic [BTN_W-1:0] double_m;
        logic [BTN_W-1:0] single_m;
    } tick_masks_t;

    localparam int SETTLE_MAX = (1 << DEB_W) - 1;
    localparam int HOLD_MAX   = (1 << LONG_W) - 1;
    localparam int AGE_MAX    = (1 << DCLK_W) - 1;

    int deb_ticks, dclk_ticks, long_ticks;

    logic prev_down  [BTN_W];
    logic deb_state  [BTN_W];
    logic long_seen  [BTN_W];
    logic rel_pend   [BTN_W];
    int   settle_cnt [BTN_W];
    int   hold_cnt   [BTN_W];
    int   rel_age    [BTN_W];

    tick_masks_t expected_masks_q [$];
    tick_masks_t want, got;

    initial begin
        fail_count  = 0;
        results_due = 0;
    end

    function automatic void clear_buttons();
        deb_ticks  = DEB_RST;
        dclk_ticks = DCLK_RST;
        long_ticks = LONG_RST;
        for (int b = 0; b < BTN_W; b++) begin
            prev_down[b]  = 1'b0;
            deb_state[b]  = 1'b0;
            long_seen[b]  = 1'b0;
            rel_pend[b]   = 1'b0;
            settle_cnt[b] = 0;
            hold_cnt[b]   = 0;
            rel_age[b]    = 0;
        end
    endfunction

    // One poll tick over all buttons; compares use the unsaturated counts.
    function automatic tick_masks_t classify_tick(input logic [BTN_W-1:0] levels);
        tick_masks_t r;
        int          settle, hold, age;
        logic        raw;
        r = '0;
        for (int b = 0; b < BTN_W; b++) begin
            raw    = ~levels[b];
            settle = settle_cnt[b] + 1;
            hold   = hold_cnt[b] + 1;
            age    = rel_age[b] + 1;
            if (raw != prev_down[b]) begin
                prev_down[b] = raw;
                settle       = 0;
            end
            if (settle >= deb_ticks && raw != deb_state[b]) begin
                deb_state[b] = raw;
                if (raw) begin
                    hold         = 0;
                    long_seen[b] = 1'b0;
                end else if (!long_seen[b]) begin
                    if (rel_pend[b] && age <= dclk_ticks) begin
                        r.double_m[b] = 1'b1;
                        rel_pend[b]   = 1'b0;
                    end else begin
                        // older click whose window just closed goes out as single
                        if (rel_pend[b])
                            r.single_m[b] = 1'b1;
                        rel_pend[b] = 1'b1;
                        age         = 0;
                    end
                end else begin
                    rel_pend[b] = 1'b0;
                end
            end
            if (deb_state[b] && !long_seen[b] && hold >= long_ticks) begin
                long_seen[b] = 1'b1;
                r.long_m[b]  = 1'b1;
                rel_pend[b]  = 1'b0;
            end
            if (rel_pend[b] && age > dclk_ticks) begin
                r.single_m[b] = 1'b1;
                rel_pend[b]   = 1'b0;
            end
            settle_cnt[b]  = (settle > SETTLE_MAX) ? SETTLE_MAX : settle;
            hold_cnt[b]    = (hold > HOLD_MAX) ? HOLD_MAX : hold;
            rel_age[b]     = (age > AGE_MAX) ? AGE_MAX : age;
            r.pressed_m[b] = deb_state[b];
        end
        return r;
    endfunction

    function automatic void check_mask(input string what, input logic [BTN_W-1:0] exp_v,
                                       input logic [BTN_W-1:0] act_v);
        if (exp_v !== act_v) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, exp_v, act_v);
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_buttons();
            expected_masks_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_DEBOUNCE:     deb_ticks  = cfg_data[DEB_W-1:0];
                    REG_DOUBLE_CLICK: dclk_ticks = cfg_data[DCLK_W-1:0];
                    REG_LONG_PRESS:   long_ticks = cfg_data[LONG_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_masks_q.push_back(classify_tick(s_tdata));
            if (m_tvalid && m_tready) begin
                got = tick_masks_t'(m_tdata);
                if (expected_masks_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: result with nothing expected, expected none, got %h",
                             $time, m_tdata);
                end else begin
                    want = expected_masks_q.pop_front();
                    check_mask("single_mask", want.single_m, got.single_m);
                    check_mask("double_mask", want.double_m, got.double_m);
                    check_mask("long_mask", want.long_m, got.long_m);
                    check_mask("pressed_mask", want.pressed_m, got.pressed_m);
                end
            end
        end
        results_due <= expected_masks_q.size();
    end

endmodule

// ===== verif/testbench.sv =====
// Testbench top for the button click classifier: clock, reset, poll sample
// stimulus, register writes and the verdict. Depends on bcc_pkg,
// button_click_classifier and click_event_checker.
`timescale 1ns / 1ps

module testbench;
    import bcc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    // index with no register behind it; writes must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // hand-picked press patterns, run under short timings
    localparam logic [BTN_W-1:0] DIRECTED_LEVELS [26] = '{
        16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF,
        16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000,
        16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h5555,
        16'hAAAA, 16'h5555, 16'hAAAA, 16'h00FF, 16'h00FF, 16'hFF00,
        16'hFF00, 16'hFFFF
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [BTN_W-1:0]      s_tdata   = '1;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_W-1:0]      m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int fail_count;
    int results_due;
    int cycle_count   = 0;
    int stall_trigger = 0;  // bumped to ask the receiver for a long hold-off
    bit steady        = 1'b0;  // no idling on either side while set

    // timings the block currently runs with, used to shape press lengths
    int cur_deb  = DEB_RST;
    int cur_dclk = DCLK_RST;
    int cur_long = LONG_RST;

    // intended button state (1 = held) and ticks left in that state
    logic [BTN_W-1:0] held = '0;
    int               dwell_left [BTN_W];

    button_click_classifier i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [15:0] raw_levels
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // single, double, long, pressed masks
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    click_event_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .results_due (results_due)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: random back-pressure, plus a long hold-off on request so
    // the block backs up and drops s_tready while samples keep coming.
    initial begin
        int stall_seen;
        int stall_left;
        stall_seen = 0;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (stall_seen != stall_trigger) begin
                stall_seen = stall_trigger;
                stall_left = 120;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= steady || ($urandom_range(0, 99) >= 22);
            end
        end
    end

    // How long a button stays in its next state, relative to the timings:
    // bounces shorter than debounce, clicks inside the window, holds past the
    // long-press time and gaps past the window.
    function automatic int pick_dwell(input logic now_held);
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return $urandom_range(1, cur_deb + 1);
        if (r < 50)
            return $urandom_range(cur_deb + 1, cur_deb + cur_dclk + 3);
        if (r < 75) begin
            if (now_held)
                return $urandom_range(cur_long + 1, cur_long + cur_deb + 4);
            return $urandom_range(cur_dclk + cur_deb, cur_dclk + cur_deb + 8);
        end
        return $urandom_range(1, 2 * cur_deb + cur_dclk + cur_long / 2 + 4);
    endfunction

    // Next poll sample: well-formed press patterns with a little contact
    // bounce, and now and then a sample of pure noise.
    function automatic logic [BTN_W-1:0] next_levels();
        logic [BTN_W-1:0] lv;
        for (int b = 0; b < BTN_W; b++) begin
            if (dwell_left[b] <= 0) begin
                held[b]       = ~held[b];
                dwell_left[b] = pick_dwell(held[b]);
            end
            dwell_left[b]--;
            lv[b] = ~held[b];
            if ($urandom_range(0, 99) < 2)
                lv[b] = ~lv[b];
        end
        if ($urandom_range(0, 99) < 4)
            lv = BTN_W'($urandom);
        return lv;
    endfunction

    // Offers one sample and waits for the edge it is taken; tvalid is then left
    // high unless the task idles first (drawn at 22 in a hundred, never while steady).
    task automatic send_tick(input logic [BTN_W-1:0] levels);
        s_tvalid <= 1'b1;
        s_tdata  <= levels;
        do @(posedge aclk); while (!s_tready);
        while (!steady && $urandom_range(0, 99) < 22) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    // Pause the sample stream until every result is back.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Loads all timings while idle; bits above each register's width carry
    // junk that must be dropped.
    task automatic set_timing(input int deb, input int dclk, input int lng);
        logic [CFG_DATA_W-1:0] d;
        wait_for_results();
        d = CFG_DATA_W'($urandom);
        d[DEB_W-1:0] = DEB_W'(deb);
        write_reg(REG_DEBOUNCE, d);
        write_reg(REG_SPARE, CFG_DATA_W'($urandom));
        d = CFG_DATA_W'($urandom);
        d[DCLK_W-1:0] = DCLK_W'(dclk);
        write_reg(REG_DOUBLE_CLICK, d);
        write_reg(REG_LONG_PRESS, LONG_W'(lng));
        cfg_valid <= 1'b0;
        cur_deb  = deb;
        cur_dclk = dclk;
        cur_long = lng;
    endtask

    task automatic run_ticks(input int count, input int stall_at);
        for (int k = 0; k < count; k++) begin
            if (k == stall_at)
                stall_trigger <= stall_trigger + 1;
            send_tick(next_levels());
        end
    endtask

    initial begin
        for (int b = 0; b < BTN_W; b++)
            dwell_left[b] = $urandom_range(0, 20);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset timings 15 / 200 / 500
        run_ticks(80, -1);

        // directed patterns under short timings
        set_timing(1, 2, 3);
        foreach (DIRECTED_LEVELS[n])
            send_tick(DIRECTED_LEVELS[n]);

        // zero timings: adopt at once, long fires on the press tick
        set_timing(0, 0, 0);
        run_ticks(50, -1);

        // shortest non-zero timings, with no idling on either side
        set_timing(1, 1, 1);
        steady = 1'b1;
        run_ticks(50, -1);
        steady = 1'b0;

        // longest timings; a short stretch in which nothing may fire early
        set_timing(255, 1023, 4095);
        run_ticks(40, -1);

        // random short timings; one phase carries the long receiver hold-off
        for (int p = 0; p < 8; p++) begin
            if (p == 5)
                set_timing($urandom_range(0, 40), $urandom_range(0, 300),
                           $urandom_range(0, 600));
            else
                set_timing($urandom_range(0, 8), $urandom_range(0, 40),
                           $urandom_range(0, 80));
            run_ticks(32, (p == 2) ? 10 : -1);
        end

        wait_for_results();
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/bcc_pkg.sv
rtl/bcc_lane.sv
rtl/button_click_classifier.sv
rtl/bcc_checker.sv
verif/click_event_checker.sv
verif/testbench.sv
